// ===== hw/rtl/mvn_pkg.sv =====
// Shared constants, op codes and types for the mesh vertex normal engine.
// No dependencies.
package mvn_pkg;
    localparam int MaxVerticesDefault = 1024;
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_TRI   = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;
    localparam int AccW = 26;
    localparam logic signed [AccW:0] AccMax = 27'sd33554431;
    localparam logic signed [AccW:0] AccMin = -27'sd33554432;

    typedef struct packed {
        logic        start;
        logic [34:0] vx;
        logic [34:0] vy;
        logic [34:0] vz;
    } norm_req_t;

    typedef struct packed {
        logic               done;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
    } norm_rsp_t;
endpackage

// ===== hw/rtl/mvn_normalize.sv =====
// Multi-cycle vector normalizer: prescale, squares, bit-serial sqrt, serial divides.
// Depends on mvn_pkg.
module mvn_normalize
    import mvn_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  norm_req_t req,
    output norm_rsp_t rsp
);
    localparam logic [2:0] S_IDLE = 3'd0, S_SHIFT = 3'd1, S_SQ = 3'd2, S_ROOT = 3'd3,
                           S_DIV = 3'd4, S_DONE = 3'd5;
    logic [2:0]  state_reg, state_next;
    logic [34:0] m_reg [3];
    logic [2:0]  neg_reg;
    logic [1:0]  k_reg;
    logic [49:0] s_reg;
    logic [49:0] rem_reg;
    logic [24:0] root_reg;
    logic [4:0]  cnt_reg;
    logic [40:0] num_reg;
    logic [25:0] quo_reg;
    logic [41:0] drem_reg;
    logic [5:0]  dcnt_reg;
    logic signed [15:0] out_reg [3];

    logic [47:0] sq;
    logic [51:0] trial;
    logic [49:0] rem_sh;
    logic [41:0] drem_sh;
    logic [25:0] den;
    logic [15:0] qv;
    assign sq = m_reg[k_reg][23:0] * m_reg[k_reg][23:0];
    assign rem_sh = {rem_reg[47:0], s_reg[49:48]};
    assign trial = {2'b0, rem_sh} - {25'b0, root_reg, 2'b01};
    assign den = {root_reg, 1'b0};
    assign drem_sh = {drem_reg[40:0], num_reg[40]};
    assign qv = quo_reg[15:0];

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (req.start) state_next = S_SHIFT;
            S_SHIFT: if ((m_reg[0] | m_reg[1] | m_reg[2]) < 35'd16777216) state_next = S_SQ;
            S_SQ:    if (k_reg == 2'd2) state_next = S_ROOT;
            S_ROOT:  if (cnt_reg == 5'd25) state_next = (s_reg == '0 && root_reg == '0 &&
                                                        rem_reg == '0) ? S_DONE : S_DIV;
            S_DIV:   if (k_reg == 2'd2 && dcnt_reg == 6'd41) state_next = S_DONE;
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) state_reg <= S_IDLE;
        else state_reg <= state_next;
    end

    always_ff @(posedge clk) begin
        case (state_reg)
            S_IDLE: begin
                neg_reg <= {req.vz[34], req.vy[34], req.vx[34]};
                m_reg[0] <= req.vx[34] ? -req.vx : req.vx;
                m_reg[1] <= req.vy[34] ? -req.vy : req.vy;
                m_reg[2] <= req.vz[34] ? -req.vz : req.vz;
                k_reg <= 2'd0;
                s_reg <= '0;
            end
            S_SHIFT: if ((m_reg[0] | m_reg[1] | m_reg[2]) >= 35'd16777216) begin
                m_reg[0] <= m_reg[0] >> 1;
                m_reg[1] <= m_reg[1] >> 1;
                m_reg[2] <= m_reg[2] >> 1;
            end
            S_SQ: begin
                s_reg <= s_reg + {2'b0, sq};
                k_reg <= k_reg + 2'd1;
                rem_reg <= '0;
                root_reg <= '0;
                cnt_reg <= '0;
                if (k_reg == 2'd2) out_reg <= '{default: '0};
            end
            S_ROOT: begin
                // one result bit per step, two bits of the square consumed
                if (cnt_reg == 5'd25) begin
                    s_reg <= (root_reg == '0) ? '0 : 50'd1;
                    k_reg <= 2'd0;
                    dcnt_reg <= '0;
                    drem_reg <= '0;
                    quo_reg <= '0;
                    num_reg <= ({6'b0, m_reg[0]} << 15) + {16'b0, root_reg};
                end else begin
                    s_reg <= {s_reg[47:0], 2'b00};
                    cnt_reg <= cnt_reg + 5'd1;
                    if (!trial[51]) begin
                        rem_reg <= trial[49:0];
                        root_reg <= {root_reg[23:0], 1'b1};
                    end else begin
                        rem_reg <= rem_sh;
                        root_reg <= {root_reg[23:0], 1'b0};
                    end
                end
            end
            S_DIV: begin
                if (dcnt_reg == 6'd41) begin
                    out_reg[k_reg] <= neg_reg[k_reg] ? -$signed(qv) : $signed(qv);
                    k_reg <= k_reg + 2'd1;
                    dcnt_reg <= '0;
                    drem_reg <= '0;
                    quo_reg <= '0;
                    if (k_reg != 2'd2)
                        num_reg <= ({6'b0, m_reg[k_reg + 2'd1]} << 15) + {16'b0, root_reg};
                end else begin
                    num_reg <= {num_reg[39:0], 1'b0};
                    dcnt_reg <= dcnt_reg + 6'd1;
                    if (drem_sh >= {16'b0, den}) begin
                        drem_reg <= drem_sh - {16'b0, den};
                        quo_reg <= {quo_reg[24:0], 1'b1};
                    end else begin
                        drem_reg <= drem_sh;
                        quo_reg <= {quo_reg[24:0], 1'b0};
                    end
                end
            end
            default: ;
        endcase
    end

    assign rsp.done = (state_reg == S_DONE);
    assign rsp.nx = out_reg[0];
    assign rsp.ny = out_reg[1];
    assign rsp.nz = out_reg[2];
endmodule

// ===== hw/rtl/mesh_vertex_normal_engine.sv =====
// Mesh vertex normal engine: position and accumulator memories, op sequencer.
// Depends on mvn_pkg and mvn_normalize.
// One request at a time. A load writes the position memory; a clear sweeps the
// accumulator memory one entry a cycle; a triangle reads three positions, forms the
// cross product, normalizes it in the shared normalizer (prescale, squaring, root,
// divide and finish steps) and then does three read-modify-writes, each a read
// state then a write state; a read normalizes the stored sum the same way and holds
// its result until the output register is free, then loads it there before the next
// request is taken. After reset the accumulator memory is cleared in a pass during
// which no request is accepted.
module mesh_vertex_normal_engine
    import mvn_pkg::*;
#(
    parameter int MAX_VERTICES = MaxVerticesDefault
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         op,
    input  logic [9:0]         vertex_a,
    input  logic [9:0]         vertex_b,
    input  logic [9:0]         vertex_c,
    input  logic signed [15:0] pos_x,
    input  logic signed [15:0] pos_y,
    input  logic signed [15:0] pos_z,
    input  logic               cfg_we,
    input  logic               cfg_wdata,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] normal_x,
    output logic signed [15:0] normal_y,
    output logic signed [15:0] normal_z,
    output logic               index_error
);
    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_RDA = 4'd2, S_RDB = 4'd3,
        S_RDC = 4'd4, S_CROSS = 4'd5, S_NSTART = 4'd6, S_NWAIT = 4'd7, S_ARD = 4'd8,
        S_AWR = 4'd9, S_RRD = 4'd10, S_RNORM = 4'd11, S_OUT = 4'd12, S_CROSS2 = 4'd13;

    logic [3:0]    state_reg;
    logic [AW:0]   clr_reg;
    logic          flat_reg;
    logic [AW-1:0] va_reg, vb_reg, vc_reg;
    logic [1:0]    corner_reg;
    logic          is_read_reg;
    logic          rerr_reg;

    logic [47:0]        pos_mem [MAX_VERTICES];
    logic [3*AccW-1:0]  acc_mem [MAX_VERTICES];
    logic [47:0]        pos_rd;
    logic [3*AccW-1:0]  acc_rd;
    logic [AW-1:0]      prd_addr, ard_addr;
    logic signed [16:0] pa_reg [3];
    logic signed [16:0] e0_reg [3], e1_reg [3];
    logic signed [33:0] p1_reg [3], p2_reg [3];
    logic [47:0]        pb_reg;
    norm_req_t nreq;
    norm_rsp_t nrsp;
    logic signed [15:0] n_reg [3];
    logic signed [15:0] o_reg [3];
    logic               oerr_reg;
    logic               ov_reg;

    logic               in_fire;
    logic               err_a, tri_bad;
    logic [AW-1:0]      corner_addr;
    logic signed [AccW:0] sum [3];
    logic [3*AccW-1:0]  acc_wr;

    assign in_fire = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign err_a = {7'b0, vertex_a} >= 17'(MAX_VERTICES);
    assign tri_bad = err_a || ({7'b0, vertex_b} >= 17'(MAX_VERTICES)) ||
                     ({7'b0, vertex_c} >= 17'(MAX_VERTICES));
    assign corner_addr = (corner_reg == 2'd0) ? va_reg :
                         (corner_reg == 2'd1) ? vb_reg : vc_reg;

    always_comb begin
        prd_addr = va_reg;
        if (state_reg == S_RDB) prd_addr = vb_reg;
        else if (state_reg == S_RDC) prd_addr = vc_reg;
    end
    assign ard_addr = (state_reg == S_RRD) ? va_reg : corner_addr;

    always_ff @(posedge clk) begin
        pos_rd <= pos_mem[prd_addr];
        if (in_fire && op == OP_LOAD && !err_a)
            pos_mem[AW'(vertex_a)] <= {pos_x, pos_y, pos_z};
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sum[i] = $signed(acc_rd[(2-i)*AccW +: AccW]) + AccW'(n_reg[i]);
            if (sum[i] > AccMax) sum[i] = AccMax;
            if (sum[i] < AccMin) sum[i] = AccMin;
        end
        if (flat_reg)
            acc_wr = {AccW'(n_reg[0]), AccW'(n_reg[1]), AccW'(n_reg[2])};
        else
            acc_wr = {sum[0][AccW-1:0], sum[1][AccW-1:0], sum[2][AccW-1:0]};
    end

    always_ff @(posedge clk) begin
        acc_rd <= acc_mem[ard_addr];
        if (state_reg == S_CLR)
            acc_mem[clr_reg[AW-1:0]] <= '0;
        else if (state_reg == S_AWR)
            acc_mem[corner_addr] <= acc_wr;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) flat_reg <= 1'b0;
        else if (cfg_we) flat_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= S_CLR;
            clr_reg <= '0;
            ov_reg <= 1'b0;
        end else begin
            if (ov_reg && out_ready) ov_reg <= 1'b0;
            case (state_reg)
                S_CLR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (AW+1)'(MAX_VERTICES - 1)) state_reg <= S_IDLE;
                end
                S_IDLE: if (in_fire) begin
                    case (op)
                        OP_LOAD: state_reg <= S_IDLE;
                        OP_CLEAR: begin
                            clr_reg <= '0;
                            state_reg <= S_CLR;
                        end
                        OP_TRI: if (!tri_bad) state_reg <= S_RDA;
                        OP_READ: state_reg <= err_a ? S_OUT : S_RRD;
                        default: state_reg <= S_IDLE;
                    endcase
                end
                S_RDA:    state_reg <= S_RDB;
                S_RDB:    state_reg <= S_RDC;
                S_RDC:    state_reg <= S_CROSS;
                S_CROSS:  state_reg <= S_CROSS2;
                S_CROSS2: state_reg <= S_NSTART;
                S_NSTART: state_reg <= S_NWAIT;
                S_RRD:    state_reg <= S_RNORM;
                S_RNORM:  state_reg <= S_NSTART;
                S_NWAIT: if (nrsp.done) state_reg <= is_read_reg ? S_OUT : S_ARD;
                S_ARD:    state_reg <= S_AWR;
                S_AWR:    state_reg <= (corner_reg == 2'd2) ? S_IDLE : S_ARD;
                S_OUT: if (!ov_reg) begin
                    ov_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk) begin
        if (in_fire) begin
            va_reg <= AW'(vertex_a);
            vb_reg <= AW'(vertex_b);
            vc_reg <= AW'(vertex_c);
            is_read_reg <= (op == OP_READ);
            rerr_reg <= (op == OP_READ) && err_a;
            corner_reg <= 2'd0;
        end
        if (state_reg == S_RDB)
            for (int i = 0; i < 3; i++) pa_reg[i] <= 17'(signed'(pos_rd[(2-i)*16 +: 16]));
        if (state_reg == S_RDC) pb_reg <= pos_rd;
        if (state_reg == S_CROSS)
            for (int i = 0; i < 3; i++) begin
                e0_reg[i] <= 17'(signed'(pb_reg[(2-i)*16 +: 16])) - pa_reg[i];
                e1_reg[i] <= 17'(signed'(pos_rd[(2-i)*16 +: 16])) - pa_reg[i];
            end
        if (state_reg == S_CROSS2) begin
            p1_reg[0] <= e0_reg[1] * e1_reg[2];  p2_reg[0] <= e0_reg[2] * e1_reg[1];
            p1_reg[1] <= e0_reg[2] * e1_reg[0];  p2_reg[1] <= e0_reg[0] * e1_reg[2];
            p1_reg[2] <= e0_reg[0] * e1_reg[1];  p2_reg[2] <= e0_reg[1] * e1_reg[0];
        end
        if (state_reg == S_RNORM)
            for (int i = 0; i < 3; i++) begin
                p1_reg[i] <= 34'(signed'(acc_rd[(2-i)*AccW +: AccW]));
                p2_reg[i] <= '0;
            end
        if (nrsp.done) begin
            n_reg[0] <= nrsp.nx; n_reg[1] <= nrsp.ny; n_reg[2] <= nrsp.nz;
        end
        // load the output register only once the previous result has left
        if (state_reg == S_OUT && !ov_reg) begin
            for (int i = 0; i < 3; i++) o_reg[i] <= rerr_reg ? 16'sd0 : n_reg[i];
            oerr_reg <= rerr_reg;
        end
        if (state_reg == S_AWR) corner_reg <= corner_reg + 2'd1;
    end

    always_comb begin
        nreq.start = (state_reg == S_NSTART);
        nreq.vx = 35'(p1_reg[0]) - 35'(p2_reg[0]);
        nreq.vy = 35'(p1_reg[1]) - 35'(p2_reg[1]);
        nreq.vz = 35'(p1_reg[2]) - 35'(p2_reg[2]);
    end

    mvn_normalize u_norm (.clk(clk), .rst_n(rst_n), .req(nreq), .rsp(nrsp));

    assign out_valid = ov_reg;
    assign normal_x = o_reg[0];
    assign normal_y = o_reg[1];
    assign normal_z = o_reg[2];
    assign index_error = oerr_reg;
endmodule

// ===== hw/rtl/mvn_checker.sv =====
// Port-level checks for the mesh vertex normal engine, bound to the top level.
// Depends on mesh_vertex_normal_engine ports.
module mvn_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [15:0] normal_x,
    input logic               index_error
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(normal_x)) else $error("out hold");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && index_error |-> normal_x == 16'sd0) else $error("err nonzero");
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> normal_x <= 16'sd16384 && normal_x >= -16'sd16384) else $error("range");
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid) else $error("in hold");
endmodule

bind mesh_vertex_normal_engine mvn_checker u_chk (.*);
